// ===== design/gbns_pkg.sv =====
package gbns_pkg;

    localparam int SEQ_W      = 6;
    localparam int MOD_W      = SEQ_W + 1;
    localparam int WAIT_W     = 9;
    localparam int CFG_WIN_W  = 6;
    localparam int CFG_TMO_W  = 16;
    localparam int TIME_W     = 32;
    localparam int MODE_W     = 2;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;
    localparam int MAX_WINDOW = 64;
    localparam int WAIT_DEPTH = 256;
    localparam int STEP_W     = $clog2(SEQ_W);

    localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NEW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACK  = 2'd2;

    localparam logic [0:0] REG_WINDOW  = 1'b0;
    localparam logic [0:0] REG_TIMEOUT = 1'b1;

    localparam logic [CFG_WIN_W-1:0] WINDOW_RESET  = 6'd7;
    localparam logic [CFG_TMO_W-1:0] TIMEOUT_RESET = 16'd100;

endpackage

// ===== design/gbns_mod_unit.sv =====
module gbns_mod_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gbns_pkg::SEQ_W-1:0] dividend,
    input  logic [gbns_pkg::MOD_W-1:0] modulus,
    output logic [gbns_pkg::SEQ_W-1:0] remainder,
    output logic                       done
);
    import gbns_pkg::*;

    logic [SEQ_W-1:0]  rem_reg;
    logic [SEQ_W-1:0]  rem_next;
    logic [SEQ_W-1:0]  shift_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [MOD_W-1:0]  trial;

    // One restoring step per cycle: bring in the next dividend bit and subtract if possible.
    assign trial = {rem_reg, shift_reg[SEQ_W-1]};

    always_comb
    begin
        if (trial >= modulus)
        begin
            rem_next = SEQ_W'(trial - modulus);
        end
        else
        begin
            rem_next = SEQ_W'(trial);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg   <= '0;
            shift_reg <= '0;
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg   <= '0;
                shift_reg <= dividend;
                step_reg  <= '0;
                busy_reg  <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                shift_reg <= {shift_reg[SEQ_W-2:0], 1'b0};
                step_reg  <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SEQ_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// ===== design/go_back_n_sender_window_unit.sv =====
// Channel  Signals                                        Direction
// config   psel penable pwrite paddr pwdata prdata pready  APB slave, user writes when idle
// input    in_valid in_ready mode ack_seq                  one event per transaction
// output   out_valid out_ready sent_valid sent_seq ...     one result per transaction
//
// Each transaction passes through acceptance, six steps of the two remainder units that
// reduce the base and ACK sequence numbers modulo the window plus one, a state that sees
// them finish, and one update. The stamp memory is read at acceptance and written in the
// update cycle. A result waits in the output register; the next transaction is accepted
// meanwhile. Reset clears all counters and restores the default configuration; the stamp
// memory is not cleared. The block does not enforce idle-only configuration writes.
module go_back_n_sender_window_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gbns_pkg::ADDR_W-1:0] paddr,
    input  logic [gbns_pkg::DATA_W-1:0] pwdata,
    output logic [gbns_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gbns_pkg::MODE_W-1:0] mode,
    input  logic [gbns_pkg::SEQ_W-1:0]  ack_seq,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        sent_valid,
    output logic [gbns_pkg::SEQ_W-1:0]  sent_seq,
    output logic                        timed_out,
    output logic                        released,
    output logic                        dropped,
    output logic [gbns_pkg::SEQ_W-1:0]  in_flight,
    output logic [gbns_pkg::WAIT_W-1:0] waiting
);
    import gbns_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_WIN_W-1:0] window_reg;
    logic [CFG_TMO_W-1:0] timeout_reg;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [SEQ_W-1:0]    base_reg, base_next;
    logic [SEQ_W-1:0]    flight_reg, flight_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;
    logic [SEQ_W-1:0]    head_reg, head_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                out_valid_reg, out_valid_next;
    logic                sent_reg, sent_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic                tmo_reg, tmo_next;
    logic                rel_reg, rel_next;
    logic                drop_reg, drop_next;

    logic [TIME_W-1:0]   stamp_mem [MAX_WINDOW];
    logic [TIME_W-1:0]   stamp_reg;
    logic                wr_en;
    logic [SEQ_W-1:0]    wr_addr;
    logic [TIME_W-1:0]   wr_data;

    logic                accept;
    logic                cfg_write;
    logic [MOD_W-1:0]    k_val;
    logic [SEQ_W-1:0]    base_mod;
    logic [SEQ_W-1:0]    ack_mod;
    logic                base_done;
    logic                ack_done;

    logic [TIME_W-1:0]   time_inc;
    logic [TIME_W-1:0]   age;
    logic                expired;
    logic [SEQ_W-1:0]    flight_a;
    logic [WAIT_W-1:0]   wait_a;
    logic                can_send;
    logic [MOD_W-1:0]    seq_sum;
    logic [SEQ_W-1:0]    seq_val;
    logic [MOD_W:0]      ack_diff;
    logic [MOD_W:0]      ack_offset;
    logic                can_release;
    logic [MOD_W-1:0]    base_inc;
    logic [SEQ_W-1:0]    base_adv;
    logic [WAIT_W:0]     occupancy;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign k_val     = {1'b0, window_reg} + MOD_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= WINDOW_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_WINDOW:  window_reg  <= pwdata[CFG_WIN_W-1:0];
                REG_TIMEOUT: timeout_reg <= pwdata[CFG_TMO_W-1:0];
                default:     window_reg  <= window_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW:  prdata = {{(DATA_W - CFG_WIN_W){1'b0}}, window_reg};
            REG_TIMEOUT: prdata = {{(DATA_W - CFG_TMO_W){1'b0}}, timeout_reg};
            default:     prdata = '0;
        endcase
    end

    gbns_mod_unit u_base_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (base_reg),
        .modulus   (k_val),
        .remainder (base_mod),
        .done      (base_done)
    );

    gbns_mod_unit u_ack_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .dividend  (ack_seq),
        .modulus   (k_val),
        .remainder (ack_mod),
        .done      (ack_done)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stamp_mem[wr_addr] <= wr_data;
        end
        if (accept)
        begin
            stamp_reg <= stamp_mem[head_reg];
        end
    end

    assign time_inc = time_reg + TIME_W'(1);
    assign age      = time_inc - stamp_reg;
    assign expired  = (flight_reg != '0) && !age[TIME_W-1];
    assign flight_a = expired ? '0 : flight_reg;
    assign wait_a   = expired ? (wait_reg + {{(WAIT_W - SEQ_W){1'b0}}, flight_reg}) : wait_reg;
    assign can_send = (wait_a != '0) && (flight_a < window_reg);
    assign seq_sum  = {1'b0, base_mod} + {1'b0, flight_a};
    assign seq_val  = (seq_sum >= k_val) ? SEQ_W'(seq_sum - k_val) : SEQ_W'(seq_sum);
    assign wr_addr  = head_reg + flight_a;
    assign wr_data  = time_inc + {{(TIME_W - CFG_TMO_W){1'b0}}, timeout_reg};

    assign ack_diff = {2'b00, ack_mod} + {1'b0, k_val} - (MOD_W + 1)'(1) - {2'b00, base_mod};
    assign ack_offset = (ack_diff >= {1'b0, k_val}) ? (ack_diff - {1'b0, k_val}) : ack_diff;
    assign can_release = (flight_reg != '0) && (ack_offset < {2'b00, window_reg});
    assign base_inc = {1'b0, base_mod} + MOD_W'(1);
    assign base_adv = (base_inc == k_val) ? '0 : SEQ_W'(base_inc);
    assign occupancy = {1'b0, wait_reg} + {{(WAIT_W + 1 - SEQ_W){1'b0}}, flight_reg};

    always_comb
    begin
        state_next     = state_reg;
        time_next      = time_reg;
        base_next      = base_reg;
        flight_next    = flight_reg;
        wait_next      = wait_reg;
        head_next      = head_reg;
        mode_next      = mode_reg;
        out_valid_next = out_valid_reg;
        sent_next      = sent_reg;
        seq_next       = seq_reg;
        tmo_next       = tmo_reg;
        rel_next       = rel_reg;
        drop_next      = drop_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MOD;
                    mode_next  = mode;
                end
            end
            S_MOD:
            begin
                if (base_done && ack_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    sent_next      = 1'b0;
                    seq_next       = '0;
                    tmo_next       = 1'b0;
                    rel_next       = 1'b0;
                    drop_next      = 1'b0;
                    case (mode_reg)
                        MODE_TICK:
                        begin
                            time_next   = time_inc;
                            tmo_next    = expired;
                            flight_next = flight_a;
                            wait_next   = wait_a;
                            if (can_send)
                            begin
                                wr_en       = 1'b1;
                                sent_next   = 1'b1;
                                seq_next    = seq_val;
                                flight_next = flight_a + SEQ_W'(1);
                                wait_next   = wait_a - WAIT_W'(1);
                            end
                        end
                        MODE_NEW:
                        begin
                            if (occupancy >= (WAIT_W + 1)'(WAIT_DEPTH))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                wait_next = wait_reg + WAIT_W'(1);
                            end
                        end
                        MODE_ACK:
                        begin
                            if (can_release)
                            begin
                                rel_next    = 1'b1;
                                base_next   = base_adv;
                                head_next   = head_reg + SEQ_W'(1);
                                flight_next = flight_reg - SEQ_W'(1);
                            end
                        end
                        default:
                        begin
                            time_next = time_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            base_reg      <= '0;
            flight_reg    <= '0;
            wait_reg      <= '0;
            head_reg      <= '0;
            mode_reg      <= '0;
            out_valid_reg <= 1'b0;
            sent_reg      <= 1'b0;
            seq_reg       <= '0;
            tmo_reg       <= 1'b0;
            rel_reg       <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            base_reg      <= base_next;
            flight_reg    <= flight_next;
            wait_reg      <= wait_next;
            head_reg      <= head_next;
            mode_reg      <= mode_next;
            out_valid_reg <= out_valid_next;
            sent_reg      <= sent_next;
            seq_reg       <= seq_next;
            tmo_reg       <= tmo_next;
            rel_reg       <= rel_next;
            drop_reg      <= drop_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sent_valid = sent_reg;
    assign sent_seq   = seq_reg;
    assign timed_out  = tmo_reg;
    assign released   = rel_reg;
    assign dropped    = drop_reg;
    assign in_flight  = flight_reg;
    assign waiting    = wait_reg;

endmodule

// ===== design/gbns_checker.sv =====
module gbns_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       sent_valid,
    input logic [gbns_pkg::SEQ_W-1:0] sent_seq,
    input logic                       timed_out,
    input logic                       released,
    input logic                       dropped,
    input logic [gbns_pkg::SEQ_W-1:0] in_flight
);

    // A transaction occupies the block for several cycles.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on two consecutive cycles");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sent_seq) && $stable(in_flight))
        else $error("stalled result changed");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({released, dropped, sent_valid || timed_out}) <= 1)
        else $error("result flags from different event kinds");

    a_seq_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sent_valid |-> sent_seq == '0)
        else $error("sequence number given without a transmission");

endmodule

bind go_back_n_sender_window_unit gbns_checker u_gbns_checker (.*);
